// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define DWS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen outside reset
`define DWS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/core/dws_pkg.sv =====
// ----------------------------------------------------------------------------
// Daily window scheduler package
// Types, constants and the seconds-of-day helper shared by the scheduler.
// ----------------------------------------------------------------------------
package dws_pkg;

  localparam int unsigned HourW = 5;
  localparam int unsigned MinW  = 6;
  localparam int unsigned SecW  = 6;
  localparam int unsigned DayW  = 17;

  localparam logic [SecW-1:0]  SecPerMin    = 6'd60;
  localparam logic [MinW-1:0]  MinPerHour   = 6'd60;
  localparam logic [HourW-1:0] HoursPerDay  = 5'd24;
  localparam logic [DayW-1:0]  DaySecPerHour = 17'd3600;
  localparam logic [DayW-1:0]  DaySecPerMin  = 17'd60;

  typedef enum logic [1:0] {
    KIND_TICK     = 2'd0,
    KIND_ENABLE   = 2'd1,
    KIND_SET_TIME = 2'd2
  } dws_kind_e;

  typedef enum logic [1:0] {
    CFG_START_HOUR   = 2'd0,
    CFG_START_MINUTE = 2'd1,
    CFG_END_HOUR     = 2'd2,
    CFG_END_MINUTE   = 2'd3
  } dws_cfg_e;

  typedef struct packed {
    logic [HourW-1:0] hour;
    logic [MinW-1:0]  minute;
    logic [SecW-1:0]  second;
  } dws_time_t;

  typedef struct packed {
    logic [HourW-1:0] open_hour;
    logic [MinW-1:0]  start_minute;
    logic [HourW-1:0] close_hour;
    logic [MinW-1:0]  end_minute;
  } dws_window_t;

  function automatic logic [DayW-1:0] day_seconds(input logic [HourW-1:0] h,
                                                  input logic [MinW-1:0]  m,
                                                  input logic [SecW-1:0]  s);
    logic [DayW-1:0] hs;
    logic [DayW-1:0] ms;
    hs = DayW'(h) * DaySecPerHour;
    ms = DayW'(m) * DaySecPerMin;
    return hs + ms + DayW'(s);
  endfunction

endpackage

// ===== rtl/core/dws_calc.sv =====
// ----------------------------------------------------------------------------
// Daily window scheduler time step
// Advances the time of day by one second and tests it against the window.
// ----------------------------------------------------------------------------
module dws_calc (
  input  dws_pkg::dws_time_t   cur_i,
  input  dws_pkg::dws_window_t win_i,
  input  logic                 time_valid_i,
  output dws_pkg::dws_time_t   nxt_o,
  output logic                 in_window_o
);

  logic [dws_pkg::SecW-1:0]  sec_inc;
  logic [dws_pkg::MinW-1:0]  min_inc;
  logic [dws_pkg::HourW-1:0] hour_inc;
  logic [dws_pkg::DayW-1:0]  lo;
  logic [dws_pkg::DayW-1:0]  hi;
  logic [dws_pkg::DayW-1:0]  now;

  assign sec_inc  = cur_i.second + dws_pkg::SecW'(1);
  assign min_inc  = cur_i.minute + dws_pkg::MinW'(1);
  assign hour_inc = cur_i.hour + dws_pkg::HourW'(1);

  always_comb begin
    nxt_o = cur_i;
    if (sec_inc >= dws_pkg::SecPerMin || sec_inc == '0) begin
      nxt_o.second = '0;
      if (min_inc >= dws_pkg::MinPerHour || min_inc == '0) begin
        nxt_o.minute = '0;
        nxt_o.hour   = (hour_inc >= dws_pkg::HoursPerDay) ? '0 : hour_inc;
      end else begin
        nxt_o.minute = min_inc;
      end
    end else begin
      nxt_o.second = sec_inc;
    end
  end

  assign lo  = dws_pkg::day_seconds(win_i.open_hour, win_i.start_minute, '0);
  assign hi  = dws_pkg::day_seconds(win_i.close_hour, win_i.end_minute, '0);
  assign now = dws_pkg::day_seconds(nxt_o.hour, nxt_o.minute, nxt_o.second);

  always_comb begin
    if (!time_valid_i) begin
      in_window_o = 1'b0;
    end else if (lo <= hi) begin
      in_window_o = (now >= lo) && (now <= hi);
    end else begin
      in_window_o = (now >= lo) || (now <= hi);
    end
  end

endmodule

// ===== rtl/core/daily_window_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// Daily window scheduler
// Time-of-day clock that signals entry to and exit from a daily window.
// ----------------------------------------------------------------------------
// Flow: an accepted request is held in the request register until it fires,
//   which applies it and loads any switch event into the output register.
// Throughput: one request per cycle; only a pending event on a stalled
//   output holds the input stage.
// Reset: asynchronous, clears clock, flags, window registers and valids.
module daily_window_scheduler_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 kind_i,
  input  logic                       enable_i,
  input  logic [dws_pkg::HourW-1:0]  set_hour_i,
  input  logic [dws_pkg::MinW-1:0]   set_minute_i,
  input  logic [dws_pkg::SecW-1:0]   set_second_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       switch_on_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [1:0]                 cfg_index_i,
  input  logic [dws_pkg::MinW-1:0]   cfg_data_i
);

  `include "assert_macros.svh"

  logic                 req_v_q, req_v_d;
  dws_pkg::dws_kind_e   kind_q;
  logic                 enable_q;
  dws_pkg::dws_time_t   set_time_q;

  dws_pkg::dws_window_t win_cfg_q;
  dws_pkg::dws_time_t   time_q, time_d;
  logic                 tvalid_q, tvalid_d;
  logic                 running_q, running_d;
  logic                 active_q, active_d;

  logic                 out_v_q, out_v_d;
  logic                 out_sw_q, out_sw_d;

  dws_pkg::dws_time_t   time_adv;
  logic                 now_in;
  logic                 emit;
  logic                 fire;
  logic                 accept;

  dws_calc u_calc (
    .cur_i        (time_q),
    .win_i        (win_cfg_q),
    .time_valid_i (tvalid_q),
    .nxt_o        (time_adv),
    .in_window_o  (now_in)
  );

  assign emit       = (kind_q == dws_pkg::KIND_TICK) && running_q && (now_in != active_q);
  assign fire       = req_v_q && (!emit || !out_v_q || !out_stall_i);
  assign in_stall_o = req_v_q && !fire;
  assign accept     = in_valid_i && !in_stall_o;
  assign req_v_d    = accept ? 1'b1 : (fire ? 1'b0 : req_v_q);

  assign cfg_ready_o = 1'b1;

  always_comb begin
    time_d    = time_q;
    tvalid_d  = tvalid_q;
    running_d = running_q;
    active_d  = active_q;
    if (fire) begin
      unique case (kind_q)
        dws_pkg::KIND_TICK: begin
          if (running_q) begin
            time_d   = time_adv;
            active_d = now_in;
          end
        end
        dws_pkg::KIND_ENABLE: begin
          running_d = enable_q;
          if (!enable_q) begin
            active_d = 1'b0;
          end
        end
        dws_pkg::KIND_SET_TIME: begin
          time_d   = set_time_q;
          tvalid_d = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_v_d  = out_v_q;
    out_sw_d = out_sw_q;
    if (fire && emit) begin
      out_v_d  = 1'b1;
      out_sw_d = now_in;
    end else if (!out_stall_i) begin
      out_v_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_v_q   <= 1'b0;
      time_q    <= '0;
      tvalid_q  <= 1'b0;
      running_q <= 1'b0;
      active_q  <= 1'b0;
      out_v_q   <= 1'b0;
      win_cfg_q <= '0;
    end else begin
      req_v_q   <= req_v_d;
      time_q    <= time_d;
      tvalid_q  <= tvalid_d;
      running_q <= running_d;
      active_q  <= active_d;
      out_v_q   <= out_v_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (dws_pkg::dws_cfg_e'(cfg_index_i))
          dws_pkg::CFG_START_HOUR:   win_cfg_q.open_hour    <= cfg_data_i[dws_pkg::HourW-1:0];
          dws_pkg::CFG_START_MINUTE: win_cfg_q.start_minute <= cfg_data_i;
          dws_pkg::CFG_END_HOUR:     win_cfg_q.close_hour   <= cfg_data_i[dws_pkg::HourW-1:0];
          dws_pkg::CFG_END_MINUTE:   win_cfg_q.end_minute   <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_sw_q <= out_sw_d;
    if (accept) begin
      kind_q            <= dws_pkg::dws_kind_e'(kind_i);
      enable_q          <= enable_i;
      set_time_q.hour   <= set_hour_i;
      set_time_q.minute <= set_minute_i;
      set_time_q.second <= set_second_i;
    end
  end

  assign out_valid_o = out_v_q;
  assign switch_on_o = out_sw_q;

  `DWS_ASSERT(a_emit_state, (fire && emit) |=> (out_v_q && out_sw_q == active_q), "bad event")
  `DWS_ASSERT_NEVER(a_active_needs_time, active_q && !tvalid_q, "active without valid time")
  `DWS_ASSERT_NEVER(a_active_needs_run, active_q && !running_q, "active while disabled")

endmodule

// ===== tb/daily_window_scheduler_top_tb.sv =====
// ----------------------------------------------------------------------------
// Daily window scheduler testbench
// Drives set-time, enable and tick requests with random gaps and output stalls.
// A scoreboard keeps its own copy of the clock and window registers, predicts
// every on/off event, and compares each one with the block's output.
// ----------------------------------------------------------------------------
module daily_window_scheduler_top_tb;
  import dws_pkg::*;

  localparam logic [1:0] KindUnused = 2'd3;
  localparam int unsigned SecPerDay = 86400;

  class switch_scoreboard;
    logic [HourW-1:0] open_hour;
    logic [MinW-1:0]  start_minute;
    logic [HourW-1:0] close_hour;
    logic [MinW-1:0]  end_minute;
    logic [HourW-1:0] hours;
    logic [MinW-1:0]  minutes;
    logic [SecW-1:0]  seconds;
    bit               time_valid;
    bit               running;
    bit               window_active;
    bit               expected_switch[$];
    int               mismatches;
    int               events_checked;

    function new();
      open_hour      = '0;
      start_minute   = '0;
      close_hour     = '0;
      end_minute     = '0;
      hours          = '0;
      minutes        = '0;
      seconds        = '0;
      time_valid     = 1'b0;
      running        = 1'b0;
      window_active  = 1'b0;
      mismatches     = 0;
      events_checked = 0;
    endfunction

    function void set_register(dws_cfg_e idx, logic [MinW-1:0] data);
      case (idx)
        CFG_START_HOUR:   open_hour    = data[HourW-1:0];
        CFG_START_MINUTE: start_minute = data;
        CFG_END_HOUR:     close_hour   = data[HourW-1:0];
        CFG_END_MINUTE:   end_minute   = data;
        default: ;
      endcase
    endfunction

    function int unsigned seconds_of_day(int unsigned h, int unsigned m, int unsigned s);
      return h * 3600 + m * 60 + s;
    endfunction

    function bit in_window();
      int unsigned open_at;
      int unsigned close_at;
      int unsigned now_at;
      if (!time_valid) return 1'b0;
      open_at  = seconds_of_day(open_hour, start_minute, 0);
      close_at = seconds_of_day(close_hour, end_minute, 0);
      now_at   = seconds_of_day(hours, minutes, seconds);
      if (open_at <= close_at) return (now_at >= open_at) && (now_at <= close_at);
      return (now_at >= open_at) || (now_at <= close_at);
    endfunction

    function void advance_clock();
      seconds = seconds + 1'b1;
      if (seconds >= SecPerMin || seconds == '0) begin
        seconds = '0;
        minutes = minutes + 1'b1;
        if (minutes >= MinPerHour || minutes == '0) begin
          minutes = '0;
          hours   = hours + 1'b1;
          if (hours >= HoursPerDay) hours = '0;
        end
      end
    endfunction

    function void note_request(logic [1:0] kind, logic en, logic [HourW-1:0] h,
                               logic [MinW-1:0] m, logic [SecW-1:0] s);
      bit now_in;
      case (kind)
        KIND_ENABLE: begin
          running = en;
          if (!running) window_active = 1'b0;
        end
        KIND_SET_TIME: begin
          hours      = h;
          minutes    = m;
          seconds    = s;
          time_valid = 1'b1;
        end
        KIND_TICK: begin
          if (running) begin
            advance_clock();
            now_in = in_window();
            if (now_in != window_active) begin
              window_active = now_in;
              expected_switch.push_back(now_in);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_switch(logic actual);
      bit want;
      if (expected_switch.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected switch event, switch_on %0b", actual);
        return;
      end
      want = expected_switch.pop_front();
      events_checked++;
      if (actual !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("switch_on mismatch: expected %0b, got %0b", want, actual);
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [1:0]        kind_i;
  logic              enable_i;
  logic [HourW-1:0]  set_hour_i;
  logic [MinW-1:0]   set_minute_i;
  logic [SecW-1:0]   set_second_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic              switch_on_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [1:0]        cfg_index_i;
  logic [MinW-1:0]   cfg_data_i;

  switch_scoreboard  sb;
  bit                tx_gaps;
  bit                rx_gaps;
  int                pressure_cycles;
  int                requests_sent;
  int                window_settings;

  daily_window_scheduler_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .enable_i     (enable_i),
    .set_hour_i   (set_hour_i),
    .set_minute_i (set_minute_i),
    .set_second_i (set_second_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .switch_on_o  (switch_on_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic send_request(logic [1:0] kind, logic en, logic [HourW-1:0] h,
                              logic [MinW-1:0] m, logic [SecW-1:0] s);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 11) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i   = 1'b1;
    kind_i       = kind;
    enable_i     = en;
    set_hour_i   = h;
    set_minute_i = m;
    set_second_i = s;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(kind, en, h, m, s);
    requests_sent++;
  endtask

  task automatic send_tick();
    send_request(KIND_TICK, 1'($urandom), 5'($urandom), 6'($urandom), 6'($urandom));
  endtask

  task automatic send_enable(logic en);
    send_request(KIND_ENABLE, en, 5'($urandom), 6'($urandom), 6'($urandom));
  endtask

  task automatic send_set_time(int unsigned tod);
    tod = tod % SecPerDay;
    send_request(KIND_SET_TIME, 1'($urandom), HourW'(tod / 3600),
                 MinW'((tod % 3600) / 60), SecW'(tod % 60));
  endtask

  task automatic write_register(dws_cfg_e idx, logic [MinW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_register(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_window(logic [MinW-1:0] sh, logic [MinW-1:0] sm,
                            logic [MinW-1:0] eh, logic [MinW-1:0] em);
    write_register(CFG_START_HOUR, sh);
    write_register(CFG_START_MINUTE, sm);
    write_register(CFG_END_HOUR, eh);
    write_register(CFG_END_MINUTE, em);
    window_settings++;
  endtask

  // drop valid, drain all expected events, then let the pipeline empty
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.expected_switch.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic run_phase(int count);
    int unsigned target;
    int unsigned lead;
    int unsigned n;
    int          sent;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(0, 9))
        0: begin
          n = $urandom_range(0, 3);
          send_request(n[1:0], 1'($urandom), 5'($urandom), 6'($urandom), 6'($urandom));
          if (n[1:0] != KindUnused) sent++;
        end
        1: begin
          send_enable(1'b0);
          repeat ($urandom_range(0, 3)) send_tick();
          send_enable(1'b1);
          sent += 2;
        end
        default: begin
          if (!sb.running) begin
            send_enable(1'b1);
            sent++;
          end
          case ($urandom_range(0, 3))
            0: target = sb.seconds_of_day(sb.open_hour, sb.start_minute, 0);
            1: target = sb.seconds_of_day(sb.close_hour, sb.end_minute, 0) + 1;
            2: target = 0;
            default: target = $urandom_range(0, SecPerDay - 1);
          endcase
          lead = $urandom_range(1, 20);
          send_set_time(target + 2 * SecPerDay - lead);
          n = lead + $urandom_range(0, 8);
          repeat (n) send_tick();
          sent += n + 1;
        end
      endcase
    end
  endtask

  initial begin
    int n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (pressure_cycles != 0) begin
        @(negedge clk_i);
        out_stall_i = 1'b1;
        repeat (pressure_cycles) @(posedge clk_i);
        pressure_cycles = 0;
      end
      n = rx_gaps ? $urandom_range(0, 11) : 0;
      @(negedge clk_i);
      out_stall_i = (n != 0);
      do @(posedge clk_i); while (!out_valid_o);
      if (n != 0) begin
        repeat (n - 1) @(posedge clk_i);
        @(negedge clk_i);
        out_stall_i = 1'b0;
        do @(posedge clk_i); while (!out_valid_o);
      end
      sb.check_switch(switch_on_o);
    end
  end

  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int p;
    sb              = new();
    tx_gaps         = 1'b1;
    rx_gaps         = 1'b1;
    pressure_cycles = 0;
    requests_sent   = 0;
    window_settings = 0;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    kind_i          = KIND_TICK;
    enable_i        = 1'b0;
    set_hour_i      = '0;
    set_minute_i    = '0;
    set_second_i    = '0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = CFG_START_HOUR;
    cfg_data_i      = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    settle();

    // window covers the first minute of the day, end second inclusive
    set_window(6'd0, 6'd0, 6'd0, 6'd1);
    send_tick();
    send_request(KindUnused, 1'b0, '0, '0, '0);
    send_enable(1'b1);
    send_tick();
    send_tick();
    send_request(KIND_SET_TIME, 1'b0, 5'd0, 6'd0, 6'd58);
    send_tick();
    send_tick();
    send_tick();
    send_request(KIND_SET_TIME, 1'b1, 5'd31, 6'd63, 6'd63);
    send_tick();
    send_enable(1'b0);
    send_tick();
    send_enable(1'b1);
    send_tick();
    send_set_time(SecPerDay - 1);
    send_tick();
    send_enable(1'b0);
    send_request(KIND_SET_TIME, 1'b0, 5'd0, 6'd0, 6'd0);
    send_enable(1'b1);
    send_tick();
    send_request(KindUnused, 1'b1, 5'h1f, 6'h3f, 6'h3f);
    send_set_time(3599);
    send_tick();
    settle();

    for (p = 0; p < 8; p++) begin
      case (p)
        0: set_window(6'd0, 6'd0, 6'd0, 6'd0);
        1: set_window(6'd23, 6'd59, 6'd0, 6'd0);
        2: set_window(6'd12, 6'd30, 6'd12, 6'd31);
        3: set_window(6'd31, 6'd63, 6'd31, 6'd63);
        4: set_window(6'd22, 6'd0, 6'd6, 6'd0);
        5: set_window(6'd0, 6'd0, 6'd23, 6'd59);
        default: set_window(6'($urandom), 6'($urandom), 6'($urandom), 6'($urandom));
      endcase
      tx_gaps = !(p == 1 || p == 2 || p == 5);
      rx_gaps = !(p == 3 || p == 5);
      if (p == 2) pressure_cycles = 400;
      run_phase(200);
      settle();
    end

    $display("Covered %0d requests under %0d window settings, including a long output hold.",
             requests_sent, window_settings);
    $display("Checked %0d switch events, %0d mismatches.", sb.events_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_switch.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/dws_pkg.sv
rtl/core/dws_calc.sv
rtl/core/daily_window_scheduler_top.sv
tb/daily_window_scheduler_top_tb.sv
